// ===== hw/rtl/e2s_pkg.sv =====
package e2s_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_OUT_CAPACITY    = 2'd0;
  localparam logic [1:0] REG_UPCASE_ASCII    = 2'd1;
  localparam logic [1:0] REG_SUBSTITUTE_WORD = 2'd2;

  // Final status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_ILLEGAL    = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  // EUC-JP code points
  localparam logic [7:0] EUC_SS2       = 8'h8e;
  localparam logic [7:0] EUC_SS3       = 8'h8f;
  localparam logic [7:0] EUC_GR_LO     = 8'ha1;
  localparam logic [7:0] EUC_KANA_HI   = 8'hdf;
  localparam logic [7:0] EUC_BAD_LEAD  = 8'hff;
  localparam logic [7:0] ASCII_TOP     = 8'h80;
  localparam logic [7:0] SUBST_RESET   = 8'h81;
  localparam logic [7:0] SUBST_RESET_L = 8'ha0;

  // One result transaction
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_status;
    logic [1:0]  status;
    logic [15:0] space_left;
    logic        run_end;
  } item_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [1:0]       count;
    item_t [2:0]      items;
  } bundle_t;

  // Fold a-z to A-Z when enabled
  function automatic logic [7:0] upcase(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'h61 && c <= 8'h7a) r = c - 8'h20;
    return r;
  endfunction

  // Remap a two-byte EUC kanji into the Shift-JIS layout
  function automatic logic [15:0] kanji_map(input logic [7:0] first,
                                            input logic [7:0] second);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {1'b0, first[6:0]};
    lo = {1'b0, second[6:0]};
    lo = lo + (hi[0] ? 8'h1f : 8'h7d);
    hi = ((hi - 8'h21) >> 1) + 8'h81;
    if (lo >= 8'h7f) lo = lo + 8'h01;
    if (hi > 8'h9f) hi = hi + 8'h40;
    return {hi, lo};
  endfunction

endpackage

// ===== hw/rtl/e2s_core.sv =====
module e2s_core import e2s_pkg::*; #(
  parameter int SPACE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        final_byte,
  output bundle_t     bundle
);

  logic [15:0]           out_capacity;
  logic                  upcase_ascii;
  logic [15:0]           substitute_word;

  logic [7:0]            lead_byte, lead_byte_next;
  logic [7:0]            middle_byte, middle_byte_next;
  logic [1:0]            bytes_pending, bytes_pending_next;
  logic [SPACE_BITS-1:0] space_remaining, space_next;
  logic [1:0]            sticky_status, sticky_next;
  logic                  stopped, stopped_next;

  logic [SPACE_BITS+15:0] cap_wide;
  logic [SPACE_BITS-1:0]  cap_space;
  logic [SPACE_BITS+15:0] left_wide;
  logic [1:0]             n_data;
  logic [7:0]             d0, d1;
  logic [1:0]             fin_status;
  logic                   space_lt2;
  logic [15:0]            pair_word;
  logic                   want_pair;
  item_t                  stat_item;
  item_t                  data_item;

  // Resize a written capacity to the space counter
  function automatic logic [SPACE_BITS-1:0] cfg_wide_space(input logic [15:0] v);
    logic [SPACE_BITS+15:0] w;
    w = {{SPACE_BITS{1'b0}}, v};
    return w[SPACE_BITS-1:0];
  endfunction

  // Capacity as a space count, and space as a 16-bit report
  assign cap_wide  = {{SPACE_BITS{1'b0}}, out_capacity};
  assign cap_space = cap_wide[SPACE_BITS-1:0];
  assign left_wide = {16'd0, space_next};
  assign space_lt2 = (space_remaining >> 1) == '0;

  // Decode one byte against the pending character
  always_comb begin
    lead_byte_next     = lead_byte;
    middle_byte_next   = middle_byte;
    bytes_pending_next = bytes_pending;
    space_next         = space_remaining;
    sticky_next        = sticky_status;
    stopped_next       = stopped;
    n_data             = 2'd0;
    d0                 = 8'd0;
    d1                 = 8'd0;
    want_pair          = 1'b0;
    pair_word          = substitute_word;

    if (!stopped) begin
      unique case (bytes_pending)
        2'd0: begin
          if (space_remaining == '0) begin
            sticky_next  = ST_FULL;
            stopped_next = 1'b1;
          end else if (in_byte < ASCII_TOP) begin
            n_data     = 2'd1;
            d0         = upcase(in_byte, upcase_ascii);
            space_next = space_remaining - 1'b1;
          end else if (in_byte == EUC_SS2 || in_byte == EUC_SS3 ||
                       (in_byte >= EUC_GR_LO && in_byte != EUC_BAD_LEAD)) begin
            lead_byte_next     = in_byte;
            bytes_pending_next = 2'd1;
          end else begin
            want_pair = 1'b1;
          end
        end
        2'd1: begin
          if (lead_byte == EUC_SS2) begin
            bytes_pending_next = 2'd0;
            if (in_byte >= EUC_GR_LO && in_byte <= EUC_KANA_HI) begin
              n_data     = 2'd1;
              d0         = in_byte;
              space_next = space_remaining - 1'b1;
            end else begin
              sticky_next  = ST_ILLEGAL;
              stopped_next = 1'b1;
            end
          end else if (lead_byte == EUC_SS3) begin
            middle_byte_next   = in_byte;
            bytes_pending_next = 2'd2;
          end else begin
            bytes_pending_next = 2'd0;
            if (in_byte < EUC_GR_LO || in_byte == EUC_BAD_LEAD) begin
              sticky_next  = ST_ILLEGAL;
              stopped_next = 1'b1;
            end else begin
              want_pair = 1'b1;
              pair_word = kanji_map(lead_byte, in_byte);
            end
          end
        end
        default: begin
          bytes_pending_next = 2'd0;
          if (middle_byte < ASCII_TOP || in_byte < ASCII_TOP) begin
            sticky_next  = ST_ILLEGAL;
            stopped_next = 1'b1;
          end else begin
            want_pair = 1'b1;
          end
        end
      endcase

      // Two-byte output needs two bytes of space
      if (want_pair) begin
        if (space_lt2) begin
          sticky_next        = ST_FULL;
          stopped_next       = 1'b1;
          bytes_pending_next = 2'd0;
        end else begin
          n_data     = 2'd2;
          d0         = pair_word[15:8];
          d1         = pair_word[7:0];
          space_next = space_remaining - 2'd2;
        end
      end
    end

    fin_status = (!stopped_next && bytes_pending_next != 2'd0) ? ST_INCOMPLETE
                                                               : sticky_next;
  end

  // Assemble the result transactions for this byte
  always_comb begin
    stat_item            = '0;
    stat_item.is_status  = 1'b1;
    stat_item.status     = fin_status;
    stat_item.space_left = left_wide[15:0];
    bundle.count         = n_data + {1'b0, final_byte};
    for (int i = 0; i < 3; i++) begin
      data_item          = '0;
      data_item.out_byte = (i == 0) ? d0 : d1;
      bundle.items[i]    = (2'(i) < n_data) ? data_item : stat_item;
      bundle.items[i].run_end = (2'(i) == bundle.count - 2'd1);
    end
  end

  // Hold configuration and conversion state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity    <= 16'd0;
      upcase_ascii    <= 1'b0;
      substitute_word <= {SUBST_RESET, SUBST_RESET_L};
      lead_byte       <= 8'd0;
      middle_byte     <= 8'd0;
      bytes_pending   <= 2'd0;
      space_remaining <= '0;
      sticky_status   <= ST_OK;
      stopped         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUT_CAPACITY: begin
          out_capacity    <= cfg_data;
          space_remaining <= cfg_wide_space(cfg_data);
        end
        REG_UPCASE_ASCII:    upcase_ascii    <= cfg_data[0];
        REG_SUBSTITUTE_WORD: substitute_word <= cfg_data;
        default: ;
      endcase
    end else if (accept) begin
      if (final_byte) begin
        lead_byte       <= 8'd0;
        middle_byte     <= 8'd0;
        bytes_pending   <= 2'd0;
        space_remaining <= cap_space;
        sticky_status   <= ST_OK;
        stopped         <= 1'b0;
      end else begin
        lead_byte       <= lead_byte_next;
        middle_byte     <= middle_byte_next;
        bytes_pending   <= bytes_pending_next;
        space_remaining <= space_next;
        sticky_status   <= sticky_next;
        stopped         <= stopped_next;
      end
    end
  end

endmodule

// ===== hw/rtl/e2s_outq.sv =====
module e2s_outq import e2s_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  bundle_t bundle,
  input  logic    out_ready,
  output logic    in_ready,
  output logic    out_valid,
  output item_t   out_item
);

  item_t [2:0] items;
  logic  [1:0] count;
  logic        pop;

  assign out_valid = count != 2'd0;
  assign out_item  = items[0];
  assign pop       = out_valid && out_ready;
  // Take a new bundle once the last held result leaves
  assign in_ready  = (count == 2'd0) || (count == 2'd1 && out_ready);

  // Load a bundle or shift out one result per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= bundle.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= bundle.items;
    end else if (pop) begin
      items[0] <= items[1];
      items[1] <= items[2];
    end
  end

endmodule

// ===== hw/rtl/euc_to_sjis_transcoder_unit.sv =====
// EUC-JP to Shift-JIS transcoder. Feed one EUC-JP byte per input transaction,
// with tlast on the last byte of a string; the block returns the Shift-JIS
// bytes each input completes (tuser 0) and, on the last byte, one status
// transaction (tuser 1) with the final status and the unused output space.
// tlast on the output marks the last result caused by an input byte. An input
// transaction producing up to one result is taken every cycle while the
// output is ready; one producing more holds off the next input until its
// last result leaves. The three-entry result queue drains one transaction
// per cycle while the output is ready. Write out_capacity before each
// conversion: it also reloads the space counter.
module euc_to_sjis_transcoder_unit import e2s_pkg::*; #(
  parameter int SPACE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status,
                                      // [25:10] space_left, rest zero
  output logic        m_axis_tuser,   // is_status
  output logic        m_axis_tlast    // run_end
);

  bundle_t bundle;
  item_t   item;
  logic    accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  e2s_core #(.SPACE_BITS(SPACE_BITS)) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .in_byte    (s_axis_tdata),
    .final_byte (s_axis_tlast),
    .bundle     (bundle)
  );

  e2s_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .bundle    (bundle),
    .out_ready (m_axis_tready),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_item  (item)
  );

  // Pack the result fields
  assign m_axis_tdata = {6'd0, item.space_left, item.status, item.out_byte};
  assign m_axis_tuser = item.is_status;
  assign m_axis_tlast = item.run_end;

endmodule
